@@ hw/rtl/windowed_sample_log_assert.svh @@
// Assertion macros used by the windowed sample log RTL.
`ifndef WINDOWED_SAMPLE_LOG_ASSERT_SVH
`define WINDOWED_SAMPLE_LOG_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define WSL_ASSERT_NOW(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("windowed_sample_log: invariant violated");

// Checks that a condition holds in the cycle after a trigger.
`define WSL_ASSERT_NEXT(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("windowed_sample_log: sequence violated");

`endif

@@ hw/rtl/wsl_pkg.sv @@
// Types and constants of the windowed sample log.
`default_nettype none

package wsl_pkg;

   localparam int DefaultDepth = 16;
   localparam int NumChannels  = 3;
   localparam int MaxResults   = 48;
   localparam int TotalWidth   = $clog2(MaxResults + 1);
   localparam int LimitWidth   = 5;
   localparam int DataWidth    = 32;

   localparam logic OP_LOG      = 1'b0;
   localparam logic OP_RETRIEVE = 1'b1;

   localparam logic [1:0] CH_TEMPERATURE = 2'd0;
   localparam logic [1:0] CH_ECG         = 2'd1;
   localparam logic [1:0] CH_PULSE       = 2'd2;
   localparam logic [1:0] CH_NONE        = 2'd3;

   typedef enum logic [1:0] {
      REG_WINDOW_START = 2'd0,
      REG_WINDOW_END   = 2'd1,
      REG_COUNT_LIMIT  = 2'd2
   } wsl_reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHAN,
      S_READ,
      S_TEST,
      S_FLUSH
   } wsl_state_type;

endpackage

`default_nettype wire

@@ hw/rtl/windowed_sample_log.sv @@
// Top level of the windowed sample log: channel stores, scan sequencer and register port.
`default_nettype none

// Three-channel timestamped sample log. A log word whose channel is not none puts the sample
// and its timestamp into the channel's circular store and advances the write pointer. A retrieve
// word walks the selected channels in order temperature, ECG, pulse through one shared
// window comparator; each store entry read (reads stop at the count limit or the result cap)
// is a registered memory read and then the compare, each of the three channel slots is visited
// whether selected or not, and a flush state closes the scan and delivers the last word. The
// input is stalled from the time a retrieve word is taken until the last word is loaded into
// the result register, also while the result side stalls. The stores need no clearing pass:
// a valid bit per entry, cleared by reset, makes unwritten entries read as zero.

`include "windowed_sample_log_assert.svh"

module windowed_sample_log
   import wsl_pkg::*;
#(
   parameter int DEPTH = DefaultDepth
) (
   input  wire                   clock,
   input  wire                   reset,

   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire                   req_opcode,
   input  wire  [1:0]            req_channel,
   input  wire  [DataWidth-1:0]  req_sample_bits,
   input  wire  [DataWidth-1:0]  req_timestamp,
   input  wire  [2:0]            req_channel_mask,

   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [1:0]            rsp_out_channel,
   output logic [DataWidth-1:0]  rsp_out_timestamp,
   output logic [DataWidth-1:0]  rsp_out_sample,
   output logic                  rsp_found,
   output logic                  rsp_last,

   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire  [3:0]            paddr,
   input  wire  [DataWidth-1:0]  pwdata,
   output logic [DataWidth-1:0]  prdata,
   output logic                  pready
);

   localparam int IdxWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int AddrWidth  = 2 + IdxWidth;
   localparam int StoreDepth = NumChannels << IdxWidth;
   localparam logic [IdxWidth-1:0]   LastIdx     = IdxWidth'(DEPTH - 1);
   localparam logic [LimitWidth-1:0] DepthLimit  = LimitWidth'(DEPTH);
   localparam logic [TotalWidth-1:0] TotalLimit  = TotalWidth'(MaxResults);
   localparam logic [1:0]            ChanEnd     = 2'(NumChannels);

   logic [DataWidth-1:0]  win_start_ff;
   logic [DataWidth-1:0]  win_end_ff;
   logic [LimitWidth-1:0] count_limit_ff;
   logic                  csr_write;
   wsl_reg_type           csr_index;

   logic [2*DataWidth-1:0] store_ff [StoreDepth];
   logic [StoreDepth-1:0]  entry_valid_ff;
   logic [IdxWidth-1:0]    wp_ff [NumChannels];
   logic [2*DataWidth-1:0] rd_data_ff;
   logic                   rd_valid_ff;

   wsl_state_type         state_ff, state_in;
   logic [2:0]            mask_ff, mask_in;
   logic [1:0]            ch_ff, ch_in;
   logic [IdxWidth-1:0]   idx_ff, idx_in;
   logic [LimitWidth-1:0] sent_ff, sent_in;
   logic [TotalWidth-1:0] total_ff, total_in;

   logic                  held_valid_ff, held_valid_in;
   logic [1:0]            held_ch_ff, held_ch_in;
   logic [DataWidth-1:0]  held_ts_ff, held_ts_in;
   logic [DataWidth-1:0]  held_smp_ff, held_smp_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_ch_ff, rsp_ch_in;
   logic [DataWidth-1:0]  rsp_ts_ff, rsp_ts_in;
   logic [DataWidth-1:0]  rsp_smp_ff, rsp_smp_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  log_en;
   logic                  rd_en;
   logic [IdxWidth-1:0]   wp_sel;
   logic [IdxWidth-1:0]   wp_next;
   logic [AddrWidth-1:0]  wr_addr;
   logic [AddrWidth-1:0]  rd_addr;
   logic [LimitWidth-1:0] limit;
   logic [DataWidth-1:0]  entry_ts;
   logic [DataWidth-1:0]  entry_smp;
   logic                  hit;
   logic                  out_free;

   // Register port.
   assign pready    = 1'b1;
   assign csr_index = wsl_reg_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (csr_index)
         REG_WINDOW_START: prdata = win_start_ff;
         REG_WINDOW_END:   prdata = win_end_ff;
         REG_COUNT_LIMIT:  prdata = DataWidth'(count_limit_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff   <= '0;
         win_end_ff     <= '1;
         count_limit_ff <= LimitWidth'(16);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW_START: win_start_ff   <= pwdata;
            REG_WINDOW_END:   win_end_ff     <= pwdata;
            REG_COUNT_LIMIT:  count_limit_ff <= pwdata[LimitWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   assign limit = (count_limit_ff > DepthLimit) ? DepthLimit : count_limit_ff;

   // Log path.
   assign accept = req_valid && !req_stall;
   assign log_en = accept && (req_opcode == OP_LOG) && (req_channel != CH_NONE);

   always_comb begin
      unique case (req_channel)
         CH_TEMPERATURE: wp_sel = wp_ff[0];
         CH_ECG:         wp_sel = wp_ff[1];
         CH_PULSE:       wp_sel = wp_ff[2];
         default:        wp_sel = '0;
      endcase
   end

   assign wp_next = (wp_sel == LastIdx) ? '0 : wp_sel + 1'b1;
   assign wr_addr = {req_channel, wp_sel};
   assign rd_addr = {ch_ff, idx_ff};
   assign rd_en   = (state_ff == S_READ) && (sent_ff < limit) && (total_ff < TotalLimit);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         for (int c = 0; c < NumChannels; c++) begin
            wp_ff[c] <= '0;
         end
      end else if (log_en) begin
         entry_valid_ff[wr_addr] <= 1'b1;
         wp_ff[req_channel]      <= wp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (log_en) begin
         store_ff[wr_addr] <= {req_timestamp, req_sample_bits};
      end
      if (rd_en) begin
         rd_data_ff  <= store_ff[rd_addr];
         rd_valid_ff <= entry_valid_ff[rd_addr];
      end
   end

   // Shared window comparator.
   assign entry_ts  = rd_valid_ff ? rd_data_ff[2*DataWidth-1:DataWidth] : '0;
   assign entry_smp = rd_valid_ff ? rd_data_ff[DataWidth-1:0] : '0;
   assign hit       = (entry_ts >= win_start_ff) && (entry_ts <= win_end_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);

   // Scan sequencer. A found entry waits in the held stage until the next one shows up or
   // the scan ends, so that the final word can carry last.
   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      ch_in         = ch_ff;
      idx_in        = idx_ff;
      sent_in       = sent_ff;
      total_in      = total_ff;
      held_valid_in = held_valid_ff;
      held_ch_in    = held_ch_ff;
      held_ts_in    = held_ts_ff;
      held_smp_in   = held_smp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ch_in     = rsp_ch_ff;
      rsp_ts_in     = rsp_ts_ff;
      rsp_smp_in    = rsp_smp_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == OP_RETRIEVE)) begin
               mask_in       = req_channel_mask;
               ch_in         = CH_TEMPERATURE;
               total_in      = '0;
               held_valid_in = 1'b0;
               state_in      = S_CHAN;
            end
         end
         S_CHAN: begin
            if (ch_ff == ChanEnd) begin
               state_in = S_FLUSH;
            end else if (mask_ff[ch_ff]) begin
               sent_in  = '0;
               idx_in   = '0;
               state_in = S_READ;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
         end
         S_READ: begin
            if (rd_en) begin
               state_in = S_TEST;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = S_CHAN;
            end
         end
         S_TEST: begin
            if (!hit || !held_valid_ff || out_free) begin
               if (hit) begin
                  if (held_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_ch_in    = held_ch_ff;
                     rsp_ts_in    = held_ts_ff;
                     rsp_smp_in   = held_smp_ff;
                     rsp_found_in = 1'b1;
                     rsp_last_in  = 1'b0;
                  end
                  held_valid_in = 1'b1;
                  held_ch_in    = ch_ff;
                  held_ts_in    = entry_ts;
                  held_smp_in   = entry_smp;
                  sent_in       = sent_ff + 1'b1;
                  total_in      = total_ff + 1'b1;
               end
               if (idx_ff == LastIdx) begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = S_CHAN;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ch_in     = held_valid_ff ? held_ch_ff : CH_TEMPERATURE;
               rsp_ts_in     = held_valid_ff ? held_ts_ff : '0;
               rsp_smp_in    = held_valid_ff ? held_smp_ff : '0;
               rsp_found_in  = held_valid_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mask_ff       <= '0;
         ch_ff         <= '0;
         idx_ff        <= '0;
         sent_ff       <= '0;
         total_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_ff       <= mask_in;
         ch_ff         <= ch_in;
         idx_ff        <= idx_in;
         sent_ff       <= sent_in;
         total_ff      <= total_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ch_ff   <= held_ch_in;
      held_ts_ff   <= held_ts_in;
      held_smp_ff  <= held_smp_in;
      rsp_ch_ff    <= rsp_ch_in;
      rsp_ts_ff    <= rsp_ts_in;
      rsp_smp_ff   <= rsp_smp_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_ch_ff;
   assign rsp_out_timestamp = rsp_ts_ff;
   assign rsp_out_sample    = rsp_smp_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_last          = rsp_last_ff;

   `WSL_ASSERT_NOW(a_empty_is_last, !(rsp_valid_ff && !rsp_found_ff) || rsp_last_ff)
   `WSL_ASSERT_NOW(a_total_capped, total_ff <= TotalLimit)
   `WSL_ASSERT_NEXT(a_retrieve_starts, accept && (req_opcode == OP_RETRIEVE), state_ff == S_CHAN)
   `WSL_ASSERT_NEXT(a_hit_is_held, (state_ff == S_TEST) && hit && (!held_valid_ff || out_free), held_valid_ff)

endmodule

`default_nettype wire

@@ tb/windowed_sample_log_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the windowed sample log: a directed table, then random words.
module windowed_sample_log_test;
   import wsl_pkg::*;

   localparam int Depth        = DefaultDepth;
   localparam int PtrWidth     = $clog2(Depth);
   localparam int CycleLimit   = 500000;
   localparam int SettleCycles = 20;
   localparam int PhaseWords   = 64;

   typedef struct packed {
      logic                 op;
      logic [1:0]           chan;
      logic [DataWidth-1:0] value;
      logic [DataWidth-1:0] stamp;
      logic [2:0]           mask;
   } log_word_type;

   typedef struct packed {
      logic [1:0]           chan;
      logic [DataWidth-1:0] stamp;
      logic [DataWidth-1:0] value;
      logic                 found;
      logic                 last;
   } log_entry_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_type;

   typedef struct packed {
      row_kind_type         kind;
      wsl_reg_type          reg_sel;
      logic [DataWidth-1:0] reg_value;
      log_word_type         w;
      row_check_type        check;
      log_entry_type        want;
   } stim_row_type;

   localparam log_word_type  NoWord      = '0;
   localparam log_entry_type NoEntry     = '0;
   localparam log_entry_type EmptyAnswer = '{CH_TEMPERATURE, 32'h0, 32'h0, 1'b0, 1'b1};

   localparam stim_row_type DirectedRows [25] = '{
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_TEMPERATURE, 32'h0, 32'h0, 3'b000}, CHK_ONE, EmptyAnswer},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_TEMPERATURE, 32'h0, 32'h0, 3'b001}, CHK_MODEL, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_LOG, CH_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'b111}, CHK_NONE, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_PULSE, 32'h0, 32'h0, 3'b100}, CHK_MODEL, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_LOG, CH_TEMPERATURE, 32'hFFFFFFFF, 32'hFFFFFFFF, 3'b000}, CHK_MODEL, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_LOG, CH_ECG, 32'h0, 32'h0, 3'b111}, CHK_MODEL, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_LOG, CH_PULSE, 32'h80000001, 32'h7FFFFFFF, 3'b010}, CHK_MODEL, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_LOG, CH_TEMPERATURE, 32'h12345678, 32'h00000001, 3'b101}, CHK_MODEL, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_LOG, CH_PULSE, 32'h0000FFFF, 32'hFFFF0000, 3'b000}, CHK_MODEL, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_ECG, 32'h0, 32'h0, 3'b111}, CHK_MODEL, NoEntry},
      '{ROW_CSR, REG_COUNT_LIMIT, 32'd0, NoWord, CHK_NONE, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_TEMPERATURE, 32'h0, 32'h0, 3'b111}, CHK_ONE, EmptyAnswer},
      '{ROW_CSR, REG_COUNT_LIMIT, 32'd31, NoWord, CHK_NONE, NoEntry},
      '{ROW_CSR, REG_WINDOW_START, 32'hFFFFFFFF, NoWord, CHK_NONE, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_TEMPERATURE, 32'h0, 32'h0, 3'b111}, CHK_MODEL, NoEntry},
      '{ROW_CSR, REG_WINDOW_START, 32'd5, NoWord, CHK_NONE, NoEntry},
      '{ROW_CSR, REG_WINDOW_END, 32'd4, NoWord, CHK_NONE, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_TEMPERATURE, 32'h0, 32'h0, 3'b111}, CHK_ONE, EmptyAnswer},
      '{ROW_CSR, REG_WINDOW_START, 32'h0, NoWord, CHK_NONE, NoEntry},
      '{ROW_CSR, REG_WINDOW_END, 32'hFFFFFFFF, NoWord, CHK_NONE, NoEntry},
      '{ROW_CSR, REG_COUNT_LIMIT, 32'd1, NoWord, CHK_NONE, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_TEMPERATURE, 32'h0, 32'h0, 3'b111}, CHK_MODEL, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_TEMPERATURE, 32'h0, 32'h0, 3'b110}, CHK_MODEL, NoEntry},
      '{ROW_CSR, REG_COUNT_LIMIT, 32'd16, NoWord, CHK_NONE, NoEntry},
      '{ROW_WORD, REG_WINDOW_START, 32'h0,
        '{OP_RETRIEVE, CH_TEMPERATURE, 32'h0, 32'h0, 3'b011}, CHK_MODEL, NoEntry}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = OP_LOG;
   logic [1:0]           req_channel = CH_TEMPERATURE;
   logic [DataWidth-1:0] req_sample_bits = '0;
   logic [DataWidth-1:0] req_timestamp = '0;
   logic [2:0]           req_channel_mask = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_out_channel;
   logic [DataWidth-1:0] rsp_out_timestamp;
   logic [DataWidth-1:0] rsp_out_sample;
   logic                 rsp_found;
   logic                 rsp_last;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [3:0]           paddr = '0;
   logic [DataWidth-1:0] pwdata = '0;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   logic [DataWidth-1:0]  stamp_mem [NumChannels][Depth];
   logic [DataWidth-1:0]  value_mem [NumChannels][Depth];
   logic [PtrWidth-1:0]   wr_ptr [NumChannels];
   logic [DataWidth-1:0]  win_lo;
   logic [DataWidth-1:0]  win_hi;
   logic [LimitWidth-1:0] limit_reg;
   log_entry_type         scan_hits [$];
   log_entry_type         pending_entries [$];
   int                    idle_pct = 0;
   int                    stall_pct = 0;
   int                    mismatches = 0;
   int unsigned           cycle_count;

   windowed_sample_log uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s, got %h, expected %h", $time, field, got, want);
      mismatches++;
   endtask

   // Updates the store mirror for a log word, or fills scan_hits with what a retrieve returns.
   function automatic void predict_log_word(input log_word_type w);
      int            cap;
      int            sent;
      log_entry_type hit;
      scan_hits.delete();
      if (w.op == OP_LOG) begin
         if (w.chan != CH_NONE) begin
            stamp_mem[w.chan][wr_ptr[w.chan]] = w.stamp;
            value_mem[w.chan][wr_ptr[w.chan]] = w.value;
            wr_ptr[w.chan] = (wr_ptr[w.chan] == PtrWidth'(Depth - 1)) ? '0
                                                                         : wr_ptr[w.chan] + 1'b1;
         end
         return;
      end
      cap = (int'(limit_reg) > Depth) ? Depth : int'(limit_reg);
      for (int c = 0; c < NumChannels; c++) begin
         if (!w.mask[c]) continue;
         sent = 0;
         for (int i = 0; i < Depth; i++) begin
            if (sent >= cap || scan_hits.size() >= MaxResults) break;
            if (stamp_mem[c][i] >= win_lo && stamp_mem[c][i] <= win_hi) begin
               scan_hits.push_back(log_entry_type'{2'(c), stamp_mem[c][i], value_mem[c][i],
                                                   1'b1, 1'b0});
               sent++;
            end
         end
      end
      if (scan_hits.size() == 0) begin
         scan_hits.push_back(EmptyAnswer);
      end else begin
         hit = scan_hits.pop_back();
         hit.last = 1'b1;
         scan_hits.push_back(hit);
      end
   endfunction

   task automatic send_word(input log_word_type w, input row_check_type check,
                            input log_entry_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= w.op;
      req_channel <= w.chan;
      req_sample_bits <= w.value;
      req_timestamp <= w.stamp;
      req_channel_mask <= w.mask;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_log_word(w);
      unique case (check)
         CHK_MODEL: begin
            foreach (scan_hits[k]) pending_entries.push_back(scan_hits[k]);
         end
         CHK_ONE: begin
            pending_entries.push_back(want);
         end
         default: begin
         end
      endcase
   endtask

   // Waits until the block is idle, then writes a register and reads it back.
   task automatic write_register(input wsl_reg_type sel, input logic [DataWidth-1:0] value);
      logic [DataWidth-1:0] readback;
      logic [DataWidth-1:0] stored;
      req_valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      unique case (sel)
         REG_WINDOW_START: win_lo = value;
         REG_WINDOW_END:   win_hi = value;
         default:          limit_reg = value[LimitWidth-1:0];
      endcase
      stored = value;
      if (sel == REG_COUNT_LIMIT) begin
         stored = DataWidth'(limit_reg);
         readback = DataWidth'(readback[LimitWidth-1:0]);
      end
      if (readback != stored) report_mismatch("register readback", readback, stored);
   endtask

   // Mostly log words with stamps in a narrow range so that the windows catch a fair share.
   task automatic run_random_phase(input int send_idle, input int recv_stall);
      log_word_type w;
      int           taken;
      idle_pct = send_idle;
      stall_pct = recv_stall;
      taken = 0;
      while (taken < PhaseWords) begin
         w.op = ($urandom_range(99) < 15) ? OP_RETRIEVE : OP_LOG;
         w.chan = ($urandom_range(19) == 0) ? CH_NONE : 2'($urandom_range(2));
         w.value = $urandom;
         w.stamp = ($urandom_range(3) == 0) ? $urandom : DataWidth'($urandom_range(255));
         w.mask = 3'($urandom_range(7));
         send_word(w, CHK_MODEL, NoEntry);
         if (!(w.op == OP_LOG && w.chan == CH_NONE)) taken++;
      end
   endtask

   always @(posedge clock) begin : result_check
      log_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_entries.size() == 0) begin
            report_mismatch("unexpected word, out_timestamp", rsp_out_timestamp, 32'h0);
         end else begin
            want = pending_entries.pop_front();
            if (rsp_out_channel != want.chan)
               report_mismatch("out_channel", 32'(rsp_out_channel), 32'(want.chan));
            if (rsp_out_timestamp != want.stamp)
               report_mismatch("out_timestamp", rsp_out_timestamp, want.stamp);
            if (rsp_out_sample != want.value)
               report_mismatch("out_sample", rsp_out_sample, want.value);
            if (rsp_found != want.found)
               report_mismatch("found", 32'(rsp_found), 32'(want.found));
            if (rsp_last != want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[windowed_sample_log] ERROR");
      $finish;
   end

   initial begin : main_sequence
      stim_row_type row;
      for (int c = 0; c < NumChannels; c++) begin
         wr_ptr[c] = '0;
         for (int i = 0; i < Depth; i++) begin
            stamp_mem[c][i] = '0;
            value_mem[c][i] = '0;
         end
      end
      win_lo = '0;
      win_hi = '1;
      limit_reg = LimitWidth'(16);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DirectedRows); r++) begin
         row = DirectedRows[r];
         if (row.kind == ROW_CSR) begin
            write_register(row.reg_sel, row.reg_value);
         end else begin
            send_word(row.w, row.check, row.want);
         end
      end

      write_register(REG_WINDOW_START, DataWidth'($urandom_range(64)));
      write_register(REG_WINDOW_END, DataWidth'($urandom_range(255, 128)));
      write_register(REG_COUNT_LIMIT, DataWidth'($urandom_range(16, 1)));
      run_random_phase(9, 72);

      write_register(REG_WINDOW_START, 32'h0);
      write_register(REG_WINDOW_END, 32'hFFFFFFFF);
      write_register(REG_COUNT_LIMIT, DataWidth'($urandom_range(31, 17)));
      run_random_phase(72, 9);

      write_register(REG_WINDOW_START, DataWidth'($urandom_range(255)));
      write_register(REG_WINDOW_END, $urandom);
      write_register(REG_COUNT_LIMIT, DataWidth'($urandom_range(16)));
      run_random_phase(0, 0);

      req_valid <= 1'b0;
      while (pending_entries.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("[windowed_sample_log] OK");
      end else begin
         $display("[windowed_sample_log] ERROR");
      end
      $finish;
   end

endmodule
